// ===== hw/rtl/mts_pkg.sv =====
package mts_pkg;

    // Histogram geometry
    localparam int BIN_W      = 8;
    localparam int LEVEL_BINS = 1 << BIN_W;
    localparam int CNT_W      = 13;
    localparam int SUM_W      = CNT_W + 1;

    localparam logic [CNT_W-1:0] MAX_ITEMS = CNT_W'(4096);
    localparam logic [BIN_W-1:0] BIN_LAST  = BIN_W'(LEVEL_BINS - 1);

    // Field widths
    localparam int LEVEL_W  = 8;
    localparam int MARGIN_W = 9;
    localparam int FLOOR_W  = 8;
    localparam int THR_W    = 10;
    localparam int TSUM_W   = 11;
    localparam int CFG_W    = 9;
    localparam int IDX_W    = 1;
    localparam int IN_DW    = 8;
    localparam int OUT_DW   = 24;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MARGIN = 1'b0;
    localparam logic [IDX_W-1:0] REG_FLOOR  = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_LOAD,
        ST_DRAIN,
        ST_WALK,
        ST_PUSH
    } state_t;

endpackage

// ===== hw/rtl/median_threshold_select.sv =====
// median_threshold_select
//
// Slave stream (s_axis_*) carries light levels, one per transfer, in tdata[7:0];
// tlast closes a set. Master stream (m_axis_*) carries one result transfer per
// closed set: the threshold max(level_floor, median + margin) and the median.
// The config port (cfg_we/cfg_index/cfg_data) writes margin (index 0) and
// level_floor (index 1); write only while the block is idle.
//
// Throughput: one level per cycle while a set loads; each level does a
// read-modify-write of its bin in a 256 x 13 histogram RAM (registered read,
// back-to-back hits on the same bin forwarded). Closing a set costs a walk of
// all 256 bins through the RAM read port, one bin per cycle, which also zeroes
// each bin before the result goes to the output register. Levels beyond 4096
// in one set are dropped and flagged in tuser.
//
// Reset: a clearing pass zeroes all 256 bins, one per cycle; s_axis_tready
// stays low until that pass ends. A stalled result is held in the output
// register; the next set loads meanwhile and waits only at its own close.
module median_threshold_select (
    input  logic                              clk,
    input  logic                              rst_n,
    // level [7:0]
    input  logic [mts_pkg::IN_DW-1:0]         s_axis_tdata,
    input  logic                              s_axis_tlast,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // threshold [9:0], median_level [17:10], zero [23:18]
    output logic [mts_pkg::OUT_DW-1:0]        m_axis_tdata,
    // overflowed [0]
    output logic                              m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_we,
    input  logic [mts_pkg::IDX_W-1:0]         cfg_index,
    input  logic [mts_pkg::CFG_W-1:0]         cfg_data
);

    mts_pkg::state_t state_reg, state_next;

    // Histogram RAM
    logic [mts_pkg::CNT_W-1:0] hist_mem [mts_pkg::LEVEL_BINS];
    logic [mts_pkg::CNT_W-1:0] rd_data_reg;
    logic [mts_pkg::BIN_W-1:0] rd_addr;
    logic                      wr_en;
    logic [mts_pkg::BIN_W-1:0] wr_addr;
    logic [mts_pkg::CNT_W-1:0] wr_data;

    // Config registers
    logic [mts_pkg::MARGIN_W-1:0] margin_reg;
    logic [mts_pkg::FLOOR_W-1:0]  floor_reg;

    // Load pipeline
    logic                      in_xfer;
    logic                      kept;
    logic                      s1_vld_reg, s1_vld_next;
    logic [mts_pkg::BIN_W-1:0] s1_addr_reg, s1_addr_next;
    logic [mts_pkg::CNT_W-1:0] s1_base;
    logic [mts_pkg::CNT_W-1:0] s1_inc;
    logic                      fwd_vld_reg, fwd_vld_next;
    logic [mts_pkg::BIN_W-1:0] fwd_addr_reg;
    logic [mts_pkg::CNT_W-1:0] fwd_val_reg;
    logic [mts_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      ovf_reg, ovf_next;

    // Walk
    logic [mts_pkg::BIN_W:0]   bin_idx_reg, bin_idx_next;
    logic                      p_vld_reg, p_vld_next;
    logic [mts_pkg::BIN_W-1:0] p_addr_reg, p_addr_next;
    logic [mts_pkg::CNT_W-1:0] seen_reg, seen_next;
    logic [mts_pkg::SUM_W-1:0] seen_sum;
    logic [mts_pkg::CNT_W-2:0] rank;
    logic                      found_reg, found_next;
    logic [mts_pkg::BIN_W-1:0] median_reg, median_next;
    logic                      walk_done;

    // Result
    logic                                out_load;
    logic                                m_vld_reg, m_vld_next;
    logic [mts_pkg::OUT_DW-1:0]          m_data_reg;
    logic                                m_user_reg;
    logic signed [mts_pkg::TSUM_W-1:0]   t_sum;
    logic signed [mts_pkg::TSUM_W-1:0]   floor_s;
    logic signed [mts_pkg::TSUM_W-1:0]   thr;

    assign s_axis_tready = (state_reg == mts_pkg::ST_LOAD);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign kept          = count_reg < mts_pkg::MAX_ITEMS;
    assign rank          = count_reg[mts_pkg::CNT_W-1:1];
    assign walk_done     = p_vld_reg && (p_addr_reg == mts_pkg::BIN_LAST);
    assign out_load      = (state_reg == mts_pkg::ST_PUSH) && (!m_vld_reg || m_axis_tready);

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mts_pkg::ST_INIT:
            begin
                if (bin_idx_reg[mts_pkg::BIN_W-1:0] == mts_pkg::BIN_LAST)
                    state_next = mts_pkg::ST_LOAD;
            end
            mts_pkg::ST_LOAD:
            begin
                if (in_xfer && s_axis_tlast)
                    state_next = mts_pkg::ST_DRAIN;
            end
            mts_pkg::ST_DRAIN:
            begin
                state_next = mts_pkg::ST_WALK;
            end
            mts_pkg::ST_WALK:
            begin
                if (walk_done)
                    state_next = mts_pkg::ST_PUSH;
            end
            mts_pkg::ST_PUSH:
            begin
                if (out_load)
                    state_next = mts_pkg::ST_LOAD;
            end
            default:
            begin
                state_next = mts_pkg::ST_INIT;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and RAM port control
    // ---------------------------------------------------------------
    // Forward the bin written in the previous cycle: its read was stale.
    assign s1_base = (fwd_vld_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_val_reg
                                                                      : rd_data_reg;
    assign s1_inc   = s1_base + mts_pkg::CNT_W'(1);
    assign seen_sum = {1'b0, seen_reg} + {1'b0, rd_data_reg};

    always_comb
    begin
        rd_addr      = (state_reg == mts_pkg::ST_LOAD) ? s_axis_tdata[mts_pkg::BIN_W-1:0]
                                                       : bin_idx_reg[mts_pkg::BIN_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = s1_addr_reg;
        wr_data      = s1_inc;
        s1_vld_next  = 1'b0;
        s1_addr_next = s_axis_tdata[mts_pkg::BIN_W-1:0];
        fwd_vld_next = s1_vld_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        bin_idx_next = bin_idx_reg;
        p_vld_next   = 1'b0;
        p_addr_next  = bin_idx_reg[mts_pkg::BIN_W-1:0];
        seen_next    = seen_reg;
        found_next   = found_reg;
        median_next  = median_reg;

        if (s1_vld_reg)
            wr_en = 1'b1;

        unique case (state_reg)
            mts_pkg::ST_INIT:
            begin
                wr_en        = 1'b1;
                wr_addr      = bin_idx_reg[mts_pkg::BIN_W-1:0];
                wr_data      = '0;
                bin_idx_next = bin_idx_reg + (mts_pkg::BIN_W+1)'(1);
            end
            mts_pkg::ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (kept)
                    begin
                        s1_vld_next = 1'b1;
                        count_next  = count_reg + mts_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            mts_pkg::ST_DRAIN:
            begin
                bin_idx_next = '0;
                seen_next    = '0;
                found_next   = 1'b0;
                median_next  = '0;
            end
            mts_pkg::ST_WALK:
            begin
                if (!bin_idx_reg[mts_pkg::BIN_W])
                begin
                    p_vld_next   = 1'b1;
                    bin_idx_next = bin_idx_reg + (mts_pkg::BIN_W+1)'(1);
                end
                if (p_vld_reg)
                begin
                    // Zero the bin just read
                    wr_en     = 1'b1;
                    wr_addr   = p_addr_reg;
                    wr_data   = '0;
                    seen_next = seen_sum[mts_pkg::CNT_W-1:0];
                    if (!found_reg && (seen_sum > mts_pkg::SUM_W'(rank)))
                    begin
                        found_next  = 1'b1;
                        median_next = p_addr_reg;
                    end
                end
            end
            mts_pkg::ST_PUSH:
            begin
                if (out_load)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Threshold
    assign t_sum   = $signed({3'b000, median_reg}) +
                     $signed({{2{margin_reg[mts_pkg::MARGIN_W-1]}}, margin_reg});
    assign floor_s = $signed({3'b000, floor_reg});
    assign thr     = (t_sum < floor_s) ? floor_s : t_sum;

    always_comb
    begin
        m_vld_next = m_vld_reg;
        if (m_axis_tready)
            m_vld_next = 1'b0;
        if (out_load)
            m_vld_next = 1'b1;
    end

    // ---------------------------------------------------------------
    // Histogram RAM: one write port, one registered read port
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
            hist_mem[wr_addr] <= wr_data;
        rd_data_reg <= hist_mem[rd_addr];
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mts_pkg::ST_INIT;
            bin_idx_reg <= '0;
            s1_vld_reg  <= 1'b0;
            fwd_vld_reg <= 1'b0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            p_vld_reg   <= 1'b0;
            found_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            margin_reg  <= '0;
            floor_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bin_idx_reg <= bin_idx_next;
            s1_vld_reg  <= s1_vld_next;
            fwd_vld_reg <= fwd_vld_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            p_vld_reg   <= p_vld_next;
            found_reg   <= found_next;
            m_vld_reg   <= m_vld_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    mts_pkg::REG_MARGIN: margin_reg <= cfg_data;
                    mts_pkg::REG_FLOOR:  floor_reg  <= cfg_data[mts_pkg::FLOOR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= s1_addr_next;
        fwd_addr_reg <= s1_addr_reg;
        fwd_val_reg  <= s1_inc;
        p_addr_reg   <= p_addr_next;
        seen_reg     <= seen_next;
        median_reg   <= median_next;
        if (out_load)
        begin
            m_data_reg <= {6'b0, median_reg, thr[mts_pkg::THR_W-1:0]};
            m_user_reg <= ovf_reg;
        end
    end

    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tvalid = m_vld_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A bin update is only ever pending for a transfer taken the cycle before.
    a_s1_from_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("bin update without an input transfer");

    // The kept count never passes the set limit.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mts_pkg::MAX_ITEMS)
        else $error("item count beyond limit");

    // At the end of the walk the bins add up to the kept count.
    a_hist_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mts_pkg::ST_WALK) && walk_done
            |-> (seen_sum == mts_pkg::SUM_W'(count_reg)))
        else $error("histogram total differs from item count");

    // A non-empty set always finds its median during the walk.
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mts_pkg::ST_PUSH) && (count_reg != '0) |-> found_reg)
        else $error("median not found");

endmodule

// ===== verif/tb_median_threshold_select.sv =====
`timescale 1ns / 100ps

module tb_median_threshold_select;

    // Cycles to let pass after the last result before touching the registers
    // or ending the run: the close of a set walks all 256 bins.
    localparam int DRAIN_CYCLES   = 300;
    // Length of the receiver hold-off that backs the block up into its input.
    localparam int HOLD_CYCLES    = 1500;
    // Cycles without any transfer on either stream before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int RANDOM_LEVELS  = 1250;
    localparam int RANDOM_PHASES  = 8;

    // Ways of spreading the levels of one set over the bins
    localparam int SPREAD_ANY    = 0;
    localparam int SPREAD_NARROW = 1;
    localparam int SPREAD_FLAT   = 2;
    localparam int SPREAD_EDGES  = 3;

    typedef struct packed {
        logic [mts_pkg::THR_W-1:0]   threshold;
        logic [mts_pkg::LEVEL_W-1:0] median;
        logic                        overflowed;
    } set_result_t;

    // Histogram model of the block plus the queue of results still owed.
    class median_scoreboard;
        int unsigned                         bin_count [mts_pkg::LEVEL_BINS];
        int unsigned                         kept;
        logic                                dropped;
        logic signed [mts_pkg::MARGIN_W-1:0] margin;
        logic [mts_pkg::FLOOR_W-1:0]         floor_level;
        set_result_t                         expected_results [$];
        int                                  mismatches;

        function new();
            foreach (bin_count[b])
                bin_count[b] = 0;
            kept        = 0;
            dropped     = 1'b0;
            margin      = '0;
            floor_level = '0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [mts_pkg::IDX_W-1:0] idx,
                                logic [mts_pkg::CFG_W-1:0] data);
            if (idx == mts_pkg::REG_MARGIN)
                margin = data[mts_pkg::MARGIN_W-1:0];
            else if (idx == mts_pkg::REG_FLOOR)
                floor_level = data[mts_pkg::FLOOR_W-1:0];
        endfunction

        // Note one accepted level; on a closing level work out the set's result.
        function void take_level(logic [mts_pkg::LEVEL_W-1:0] lvl, logic lst);
            int unsigned rank;
            int unsigned seen;
            int          med_bin;
            logic        found;
            int          thr;
            set_result_t res;

            // An 8-bit level always lands inside the 256 bins, so no saturation.
            if (kept < int'(mts_pkg::MAX_ITEMS)) begin
                bin_count[lvl] += 1;
                kept           += 1;
            end
            else begin
                dropped = 1'b1;
            end
            if (!lst)
                return;

            rank    = kept / 2;
            seen    = 0;
            med_bin = 0;
            found   = 1'b0;
            for (int b = 0; b < mts_pkg::LEVEL_BINS; b++) begin
                seen += bin_count[b];
                if (!found && seen > rank) begin
                    med_bin = b;
                    found   = 1'b1;
                end
            end

            thr = med_bin + int'(margin);
            if (thr < int'(floor_level))
                thr = int'(floor_level);

            res.threshold  = thr[mts_pkg::THR_W-1:0];
            res.median     = med_bin[mts_pkg::LEVEL_W-1:0];
            res.overflowed = dropped;
            expected_results.insert(expected_results.size(), res);

            foreach (bin_count[b])
                bin_count[b] = 0;
            kept    = 0;
            dropped = 1'b0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        task check_result(logic [mts_pkg::OUT_DW-1:0] data, logic user);
            set_result_t want;

            if (expected_results.size() == 0) begin
                report($sformatf("result with nothing owed: tdata %h tuser %b", data, user));
                return;
            end
            want = expected_results.pop_front();
            if (data[mts_pkg::THR_W-1:0] !== want.threshold)
                report($sformatf("threshold %h, wanted %h",
                                 data[mts_pkg::THR_W-1:0], want.threshold));
            if (data[mts_pkg::THR_W +: mts_pkg::LEVEL_W] !== want.median)
                report($sformatf("median %h, wanted %h",
                                 data[mts_pkg::THR_W +: mts_pkg::LEVEL_W], want.median));
            if (data[mts_pkg::OUT_DW-1:mts_pkg::THR_W+mts_pkg::LEVEL_W] !== '0)
                report($sformatf("padding bits not zero: tdata %h", data));
            if (user !== want.overflowed)
                report($sformatf("overflowed %b, wanted %b", user, want.overflowed));
        endtask
    endclass

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic [mts_pkg::IN_DW-1:0]   s_axis_tdata  = '0;
    logic                        s_axis_tlast  = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [mts_pkg::OUT_DW-1:0]  m_axis_tdata;
    logic                        m_axis_tuser;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic                        cfg_we        = 1'b0;
    logic [mts_pkg::IDX_W-1:0]   cfg_index     = '0;
    logic [mts_pkg::CFG_W-1:0]   cfg_data      = '0;

    // Raised for a stretch of the run in which neither side idles.
    logic               steady        = 1'b0;
    // Bumped by the stimulus to ask the receiver for one long hold-off.
    int                 hold_ticket   = 0;
    int                 idle_cycles   = 0;

    median_scoreboard   sb = new();

    median_threshold_select u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),   // level [7:0]
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // threshold [9:0], median_level [17:10], zero [23:18]
        .m_axis_tuser  (m_axis_tuser),   // overflowed [0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offer one level, possibly after a one-cycle gap, and hold it until the
    // block takes the transfer. Valid is left high for the next level.
    task automatic send_level(input logic [mts_pkg::LEVEL_W-1:0] lvl, input logic lst);
        if (!steady && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= lvl;
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.take_level(lvl, lst);
    endtask

    // Send a whole set of n levels, the last one carrying tlast.
    task automatic run_set(input int n, input int spread);
        logic [mts_pkg::LEVEL_W-1:0] base;
        logic [mts_pkg::LEVEL_W-1:0] lvl;

        base = mts_pkg::LEVEL_W'($urandom_range(0, 255));
        for (int i = 0; i < n; i++) begin
            case (spread)
                SPREAD_NARROW: lvl = base + mts_pkg::LEVEL_W'($urandom_range(0, 7));
                SPREAD_FLAT:   lvl = base;
                SPREAD_EDGES:  lvl = $urandom_range(0, 1) ? {mts_pkg::LEVEL_W{1'b1}} : '0;
                default:       lvl = mts_pkg::LEVEL_W'($urandom_range(0, 255));
            endcase
            send_level(lvl, i == n - 1);
        end
    endtask

    // Mostly short sets, now and then a longer one; odd and even counts alike.
    task automatic random_set(output int n);
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(25, 200);
        else
            n = $urandom_range(1, 24);
        run_set(n, $urandom_range(SPREAD_ANY, SPREAD_EDGES));
    endtask

    // Write both registers on consecutive edges, keeping the write enable high.
    task automatic set_config(input int m, input logic [mts_pkg::FLOOR_W-1:0] f);
        logic [mts_pkg::CFG_W-1:0] mdata;
        logic [mts_pkg::CFG_W-1:0] fdata;

        mdata = m[mts_pkg::CFG_W-1:0];
        // Toggle the unused top bit of the floor write: it must be ignored.
        fdata = {1'($urandom_range(0, 1)), f};
        cfg_we    <= 1'b1;
        cfg_index <= mts_pkg::REG_MARGIN;
        cfg_data  <= mdata;
        @(posedge clk);
        cfg_index <= mts_pkg::REG_FLOOR;
        cfg_data  <= fdata;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(mts_pkg::REG_MARGIN, mdata);
        sb.write_reg(mts_pkg::REG_FLOOR, fdata);
    endtask

    // Drop valid, wait for every owed result, then let the block finish its walk.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Receiver: accept results with random stalls, or hold off for a long
    // stretch on request so that the block fills and stalls its input.
    initial
    begin
        int served;

        served = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_ticket != served) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                served++;
            end
            else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 7);
                @(posedge clk);
            end
        end
    end

    // Check every result transfer against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Abandon the run when neither stream has moved for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_median_threshold_select: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int sent;
        int n;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings (margin 0, floor 0): single-level sets at both
        // extremes, an even pair picking the upper median, an odd set, and
        // an even set of extremes.
        send_level(8'd0, 1'b1);
        send_level(8'd255, 1'b1);
        send_level(8'd10, 1'b0);
        send_level(8'd200, 1'b1);
        send_level(8'd7, 1'b0);
        send_level(8'd3, 1'b0);
        send_level(8'd9, 1'b1);
        send_level(8'd0, 1'b0);
        send_level(8'd255, 1'b0);
        send_level(8'd0, 1'b0);
        send_level(8'd255, 1'b1);
        settle();

        // A margin of -255 with no floor: the floor takes over.
        set_config(-255, 8'd0);
        send_level(8'd255, 1'b1);
        send_level(8'd0, 1'b1);
        settle();

        // Largest margin and highest floor: widest threshold.
        set_config(255, 8'd255);
        send_level(8'd255, 1'b1);
        send_level(8'd0, 1'b1);
        settle();

        set_config(-255, 8'd255);
        send_level(8'd0, 1'b1);
        send_level(8'd128, 1'b0);
        send_level(8'd127, 1'b1);
        settle();

        set_config(255, 8'd0);
        send_level(8'd170, 1'b0);
        send_level(8'd85, 1'b1);
        settle();

        // Random phases, each under fresh register settings.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_config(int'($urandom_range(0, 510)) - 255,
                       mts_pkg::FLOOR_W'($urandom_range(0, 255)));
            steady <= (phase == 2);
            if (phase == 4)
                hold_ticket <= hold_ticket + 1;
            sent = 0;
            while (sent < RANDOM_LEVELS / RANDOM_PHASES) begin
                random_set(n);
                sent += n;
            end
            settle();
        end

        if (sb.mismatches == 0)
            $display("tb_median_threshold_select: clean");
        else
            $display("tb_median_threshold_select: errors");
        $finish;
    end

endmodule

// ===== median_threshold_select.f =====
hw/rtl/mts_pkg.sv
hw/rtl/median_threshold_select.sv
verif/tb_median_threshold_select.sv
